### hw/rtl/assert_macros.svh
// Assertion macros used by the stereo imager core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SMSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SMSI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/smsi_pkg.sv
// Shared types, constants, the tanh table and arithmetic helpers of the stereo imager.
package smsi_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int TANH_BITS    = 8;
    localparam int TANH_ENTRIES = 1 << TANH_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DEADBAND = 328;

    localparam logic [14:0] GAIN_RESET  = 15'd8192;
    localparam logic [15:0] XOVER_RESET = 16'd1282;

    // Mode flag bit positions.
    localparam int MODE_ENABLE = 0;
    localparam int MODE_IN_MS  = 1;
    localparam int MODE_OUT_MS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic [SAMPLE_BITS-1:0]        tanh_entry_t;
    typedef tanh_entry_t                   tanh_tab_t [0:TANH_ENTRIES];

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_WIDTH   = 3'd1,
        REG_LOW_MID = 3'd2,
        REG_BALANCE = 3'd3,
        REG_DRIVE   = 3'd4,
        REG_GAIN    = 3'd5,
        REG_XOVER   = 3'd6
    } cfg_reg_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic    enable;
        logic    out_ms;
        logic    lm_on;
        logic    cd_on;
        sample_t first;
        sample_t second;
    } smsi_item_t;

    // Restoring division, used only while the table is built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(8i/N) scaled to full scale, from a Q30 exponential recurrence.
    function automatic tanh_tab_t build_tanh();
        logic [63:0] one;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] den;
        tanh_tab_t   tab;
        int          k;
        int          i;
        one  = 64'd1 << 30;
        y    = udiv64(64'd16 << 30, 64'(TANH_ENTRIES));
        term = one;
        pos  = one;
        neg  = '0;
        p    = one;
        for (k = 1; k <= 12; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if (k[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = pos - neg;
        for (i = 0; i <= TANH_ENTRIES; i++) begin
            den    = one + p;
            tab[i] = SAMPLE_BITS'(udiv64(((one - p) << (SAMPLE_BITS - 1)) + (den >> 1), den));
            p      = (p * r + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh();

    // Round to nearest by n bits, halves upwards.
    function automatic prod_t rnd_shift(input prod_t v, input int n);
        return (v + (prod_t'(1) <<< (n - 1))) >>> n;
    endfunction

    localparam prod_t SAT_HI = prod_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam prod_t SAT_LO = prod_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Saturate to the sample width.
    function automatic sample_t sat_sample(input prod_t v);
        sample_t s;
        if (v > SAT_HI) begin
            s = sample_t'(SAT_HI[SAMPLE_BITS-1:0]);
        end else if (v < SAT_LO) begin
            s = sample_t'(SAT_LO[SAMPLE_BITS-1:0]);
        end else begin
            s = sample_t'(v[SAMPLE_BITS-1:0]);
        end
        return s;
    endfunction

endpackage

### hw/rtl/smsi_front.sv
// Front end: takes pairs, converts enabled L/R input to mid/side and classifies.
module smsi_front import smsi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sample_t            s_first_sample,
    input  sample_t            s_second_sample,
    input  logic [2:0]         mode_flags,
    input  logic signed [15:0] low_mid_amount,
    input  logic signed [15:0] center_drive,
    output logic               item_valid,
    input  logic               item_ready,
    output smsi_item_t         item
);

    logic                         valid_reg;
    smsi_item_t                   item_reg;
    smsi_item_t                   item_next;
    logic signed [SAMPLE_BITS:0]  sum;
    logic signed [SAMPLE_BITS:0]  dif;

    // Classify the incoming pair.
    always_comb begin
        sum = (SAMPLE_BITS+1)'(s_first_sample) + (SAMPLE_BITS+1)'(s_second_sample);
        dif = (SAMPLE_BITS+1)'(s_first_sample) - (SAMPLE_BITS+1)'(s_second_sample);
        item_next.enable = mode_flags[MODE_ENABLE];
        item_next.out_ms = mode_flags[MODE_OUT_MS];
        item_next.lm_on  = (low_mid_amount >= DEADBAND) || (low_mid_amount <= -DEADBAND);
        item_next.cd_on  = (center_drive >= DEADBAND) || (center_drive <= -DEADBAND);
        if (!mode_flags[MODE_ENABLE] || mode_flags[MODE_IN_MS]) begin
            item_next.first  = s_first_sample;
            item_next.second = s_second_sample;
        end else begin
            item_next.first  = sample_t'(sum[SAMPLE_BITS:1]);
            item_next.second = sample_t'(dif[SAMPLE_BITS:1]);
        end
    end

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Holding register towards the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (item_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/smsi_queue.sv
// Short queue of classified items between the front and the back.
module smsi_queue import smsi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  smsi_item_t        push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output smsi_item_t        pop_item,
    output logic [QCNT_W-1:0] count
);

    smsi_item_t        slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign count      = count_reg;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/smsi_back.sv
// Back end: sequencer around one shared multiplier that processes one item at a time.
module smsi_back import smsi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    output logic               item_ready,
    input  smsi_item_t         item,
    input  logic signed [15:0] width_amount,
    input  logic signed [15:0] low_mid_amount,
    input  logic signed [15:0] balance_amount,
    input  logic signed [15:0] center_drive,
    input  logic [14:0]        output_gain,
    input  logic [15:0]        crossover_coeff,
    output logic               m_valid,
    input  logic               m_ready,
    output sample_t            m_first_out,
    output sample_t            m_second_out
);

    localparam int SIDE_W = SAMPLE_BITS + 12;
    localparam int MID_W  = SAMPLE_BITS + 2;
    localparam int V_W    = SIDE_W + 1;
    localparam int T_W    = SAMPLE_BITS + 1;
    localparam int X_W    = SAMPLE_BITS + 20;
    localparam int IDX_SH = SAMPLE_BITS + 17 - TANH_BITS;
    localparam int F_SH   = SAMPLE_BITS + 1 - TANH_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIDE_MUL,
        ST_DRIVE_MUL,
        ST_TABLE,
        ST_LP_UPD,
        ST_TANH,
        ST_LOW_BAND,
        ST_MID_DRY,
        ST_MID_MIX,
        ST_ENCODE,
        ST_BAL1,
        ST_BAL2,
        ST_GAIN1,
        ST_GAIN2,
        ST_SAT2,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic                      out_ms_reg;
    logic                      lm_on_reg;
    logic                      cd_on_reg;
    logic signed [SIDE_W-1:0]  side_reg;
    logic signed [MID_W-1:0]   mid_reg;
    logic signed [31:0]        lp_reg;
    tanh_entry_t               lo_reg;
    tanh_entry_t               hi_reg;
    logic [15:0]               frac_reg;
    logic                      neg_reg;
    logic                      clip_reg;
    logic signed [T_W-1:0]     t_reg;
    prod_t                     acc_reg;
    prod_t                     prod_reg;
    logic signed [V_W-1:0]     v1_reg;
    logic signed [V_W-1:0]     v2_reg;
    logic signed [MUL_A_W-1:0] r1_reg;
    logic signed [MUL_A_W-1:0] r2_reg;
    sample_t                   res1_reg;
    sample_t                   res2_reg;
    logic                      m_valid_reg;
    sample_t                   m_first_reg;
    sample_t                   m_second_reg;

    logic signed [17:0]        wg;
    logic signed [17:0]        lg;
    logic [16:0]               amt;
    logic [19:0]               dg;
    logic [16:0]               dry;
    logic [16:0]               bal_neg;
    logic [17:0]               gl;
    logic [17:0]               gr;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [X_W-1:0]            ax;
    logic [TANH_BITS:0]        tab_ix;
    logic [X_W-IDX_SH-1:0]     idx_full;
    logic signed [T_W-1:0]     tab_diff;
    prod_t                     t_sum;
    prod_t                     lp_sum;
    logic                      emit_fire;

    // Gains derived from the configuration.
    always_comb begin
        wg      = 18'sd32768 + 18'(width_amount);
        lg      = 18'sd32768 + 18'(low_mid_amount);
        amt     = center_drive[15] ? (17'd0 - 17'(center_drive)) : 17'(center_drive);
        dg      = 20'd32768 + {amt, 3'b000};
        dry     = 17'd32768 - amt;
        bal_neg = balance_amount[15] ? (17'd0 - 17'(balance_amount)) : 17'd0;
        gl      = 18'd65536 - (balance_amount[15] ? 18'd0 : 18'(balance_amount));
        gr      = 18'd65536 - 18'(bal_neg);
    end

    // Table lookup terms from the drive argument and the interpolation result.
    always_comb begin
        ax       = X_W'(prod_reg[PROD_W-1] ? -prod_reg : prod_reg);
        idx_full = ax[X_W-1:IDX_SH];
        tab_ix   = {1'b0, ax[IDX_SH +: TANH_BITS]};
        tab_diff = T_W'($signed({1'b0, hi_reg})) - T_W'($signed({1'b0, lo_reg}));
        t_sum    = clip_reg ? prod_t'($signed({1'b0, TANH_TAB[TANH_ENTRIES]}))
                            : prod_t'($signed({1'b0, lo_reg})) + (prod_reg >>> 16);
        lp_sum   = prod_t'(lp_reg) + rnd_shift(prod_reg, 16);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SIDE_MUL: begin
                mul_a = MUL_A_W'(side_reg);
                mul_b = MUL_B_W'(wg);
            end
            ST_DRIVE_MUL: begin
                mul_a = MUL_A_W'(mid_reg);
                mul_b = MUL_B_W'($signed({1'b0, dg}));
            end
            ST_TABLE: begin
                mul_a = MUL_A_W'(side_reg) - MUL_A_W'(lp_reg);
                mul_b = MUL_B_W'($signed({1'b0, crossover_coeff}));
            end
            ST_LP_UPD: begin
                mul_a = MUL_A_W'(tab_diff);
                mul_b = MUL_B_W'($signed({1'b0, frac_reg}));
            end
            ST_TANH: begin
                mul_a = MUL_A_W'(lp_reg);
                mul_b = MUL_B_W'(lg);
            end
            ST_LOW_BAND: begin
                mul_a = MUL_A_W'(mid_reg);
                mul_b = MUL_B_W'($signed({1'b0, dry}));
            end
            ST_MID_DRY: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'($signed({1'b0, amt}));
            end
            ST_BAL1: begin
                mul_a = MUL_A_W'(v1_reg);
                mul_b = MUL_B_W'($signed({1'b0, gl}));
            end
            ST_BAL2: begin
                mul_a = MUL_A_W'(v2_reg);
                mul_b = MUL_B_W'($signed({1'b0, gr}));
            end
            ST_GAIN1: begin
                mul_a = r1_reg;
                mul_b = MUL_B_W'($signed({1'b0, output_gain}));
            end
            ST_GAIN2: begin
                mul_a = r2_reg;
                mul_b = MUL_B_W'($signed({1'b0, output_gain}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign item_ready   = state_reg == ST_IDLE;
    assign emit_fire    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_first_out  = m_first_reg;
    assign m_second_out = m_second_reg;

    // Sequencer: each step takes the previous product and issues the next one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lp_reg      <= '0;
        end else begin
            prod_reg <= mul_a * mul_b;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        out_ms_reg <= item.out_ms;
                        lm_on_reg  <= item.lm_on;
                        cd_on_reg  <= item.cd_on;
                        mid_reg    <= MID_W'(item.first);
                        side_reg   <= SIDE_W'(item.second);
                        res1_reg   <= item.first;
                        res2_reg   <= item.second;
                        state_reg  <= item.enable ? ST_SIDE_MUL : ST_EMIT;
                    end
                end
                ST_SIDE_MUL: begin
                    state_reg <= ST_DRIVE_MUL;
                end
                ST_DRIVE_MUL: begin
                    side_reg  <= SIDE_W'(rnd_shift(prod_reg, 15));
                    state_reg <= ST_TABLE;
                end
                ST_TABLE: begin
                    neg_reg   <= prod_reg[PROD_W-1];
                    clip_reg  <= idx_full >= (X_W-IDX_SH)'(TANH_ENTRIES);
                    frac_reg  <= ax[F_SH +: 16];
                    lo_reg    <= TANH_TAB[tab_ix];
                    hi_reg    <= TANH_TAB[tab_ix + 1'b1];
                    state_reg <= ST_LP_UPD;
                end
                ST_LP_UPD: begin
                    if (lm_on_reg) begin
                        if (lp_sum > prod_t'(32'sh7fffffff)) begin
                            lp_reg <= 32'sh7fffffff;
                        end else if (lp_sum < prod_t'(-33'sh080000000)) begin
                            lp_reg <= -32'sh7fffffff - 32'sd1;
                        end else begin
                            lp_reg <= lp_sum[31:0];
                        end
                    end
                    state_reg <= ST_TANH;
                end
                ST_TANH: begin
                    t_reg     <= neg_reg ? T_W'(-t_sum) : T_W'(t_sum);
                    state_reg <= ST_LOW_BAND;
                end
                ST_LOW_BAND: begin
                    if (lm_on_reg) begin
                        side_reg <= SIDE_W'(prod_t'(side_reg) - prod_t'(lp_reg)
                                   + rnd_shift(prod_reg, 15));
                    end
                    state_reg <= ST_MID_DRY;
                end
                ST_MID_DRY: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_MID_MIX;
                end
                ST_MID_MIX: begin
                    if (cd_on_reg) begin
                        mid_reg <= MID_W'(rnd_shift(acc_reg + prod_reg, 15));
                    end
                    state_reg <= ST_ENCODE;
                end
                ST_ENCODE: begin
                    if (out_ms_reg) begin
                        v1_reg <= V_W'(mid_reg);
                        v2_reg <= V_W'(side_reg);
                    end else begin
                        v1_reg <= V_W'(mid_reg) + V_W'(side_reg);
                        v2_reg <= V_W'(mid_reg) - V_W'(side_reg);
                    end
                    state_reg <= ST_BAL1;
                end
                ST_BAL1: begin
                    state_reg <= ST_BAL2;
                end
                ST_BAL2: begin
                    r1_reg    <= MUL_A_W'(rnd_shift(prod_reg, 16));
                    state_reg <= ST_GAIN1;
                end
                ST_GAIN1: begin
                    r2_reg    <= MUL_A_W'(rnd_shift(prod_reg, 16));
                    state_reg <= ST_GAIN2;
                end
                ST_GAIN2: begin
                    res1_reg  <= sat_sample(rnd_shift(prod_reg, 13));
                    state_reg <= ST_SAT2;
                end
                ST_SAT2: begin
                    res2_reg  <= sat_sample(rnd_shift(prod_reg, 13));
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_first_reg  <= res1_reg;
                        m_second_reg <= res2_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/stereo_mid_side_imager_core.sv
// Top level of the mid/side stereo imager: configuration registers, front, queue and back.
//
//  Channel   Ports                                    Direction
//  input     s_valid s_ready s_first/second_sample    in
//  result    m_valid m_ready m_first/second_out       out
//  config    cfg_valid cfg_ready cfg_index cfg_data   in
//
// In the back end an enabled item runs through a sequence of eleven products on its one
// shared multiplier; a bypassed item goes straight from idle to emit there.
// The front end and a two-item queue accept new items while the back end works.
// Reset is synchronous and active low and clears the low-pass state and all handshakes.
// A result held on a stalled output stops the back end, and then the queue fills.
`include "assert_macros.svh"

module stereo_mid_side_imager_core import smsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sample_t     s_first_sample,
    input  sample_t     s_second_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output sample_t     m_first_out,
    output sample_t     m_second_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [2:0]         mode_reg;
    logic signed [15:0] width_reg;
    logic signed [15:0] low_mid_reg;
    logic signed [15:0] balance_reg;
    logic signed [15:0] drive_reg;
    logic [14:0]        gain_reg;
    logic [15:0]        xover_reg;

    logic               q_push_valid;
    logic               q_push_ready;
    smsi_item_t         q_push_item;
    logic               q_pop_valid;
    logic               q_pop_ready;
    smsi_item_t         q_pop_item;
    logic [QCNT_W-1:0]  q_count;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            width_reg   <= '0;
            low_mid_reg <= '0;
            balance_reg <= '0;
            drive_reg   <= '0;
            gain_reg    <= GAIN_RESET;
            xover_reg   <= XOVER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:    mode_reg    <= cfg_data[2:0];
                REG_WIDTH:   width_reg   <= cfg_data;
                REG_LOW_MID: low_mid_reg <= cfg_data;
                REG_BALANCE: balance_reg <= cfg_data;
                REG_DRIVE:   drive_reg   <= cfg_data;
                REG_GAIN:    gain_reg    <= cfg_data[14:0];
                REG_XOVER:   xover_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    smsi_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_sample  (s_first_sample),
        .s_second_sample (s_second_sample),
        .mode_flags      (mode_reg),
        .low_mid_amount  (low_mid_reg),
        .center_drive    (drive_reg),
        .item_valid      (q_push_valid),
        .item_ready      (q_push_ready),
        .item            (q_push_item)
    );

    smsi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item),
        .count      (q_count)
    );

    smsi_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (q_pop_valid),
        .item_ready      (q_pop_ready),
        .item            (q_pop_item),
        .width_amount    (width_reg),
        .low_mid_amount  (low_mid_reg),
        .balance_amount  (balance_reg),
        .center_drive    (drive_reg),
        .output_gain     (gain_reg),
        .crossover_coeff (xover_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_out     (m_first_out),
        .m_second_out    (m_second_out)
    );

    // Checks on the queue between front and back, and on reset clearing the output.
    `SMSI_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (q_count == '0) && !m_valid, "reset left items in flight")
    `SMSI_ASSERT(a_count_bound, q_count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `SMSI_ASSERT(a_no_pop_empty, (q_count == '0) |-> !q_pop_valid, "queue offers an item while empty")
    `SMSI_ASSERT(a_full_stalls, (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !q_push_ready, "queue takes an item while full")

endmodule

### sim/tb_top.sv
// Self-checking testbench for the mid/side stereo imager core.
`timescale 1ns / 100ps

module tb_top;
    import smsi_pkg::*;

    // One output sample pair.
    typedef struct {
        sample_t first;
        sample_t second;
    } sample_pair_t;

    // Scoreboard: an own model of the imager and the pairs it expects.
    class imager_scoreboard;
        sample_pair_t      expected_pairs[$];
        longint unsigned   tanh_lut[0:TANH_ENTRIES];
        logic [2:0]        mode;
        longint            width_amt;
        longint            low_mid_amt;
        longint            balance_amt;
        longint            drive_amt;
        longint            gain;
        longint            xover;
        longint            side_lp;
        int                errors;
        int                results_seen;
        int                shaped_items;

        function new();
            longint unsigned unit;
            longint unsigned step;
            longint unsigned term;
            longint unsigned pos;
            longint unsigned neg;
            longint unsigned ratio;
            longint unsigned p;
            longint unsigned den;
            unit = 64'd1 << 30;
            step = (64'd16 << 30) / TANH_ENTRIES;
            term = unit;
            pos  = unit;
            neg  = 0;
            p    = unit;
            // Series for exp(-2*8/N), then powers of it give the table points.
            for (int k = 1; k <= 12; k++) begin
                term = ((term * step) >> 30) / k;
                if (k % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            ratio = pos - neg;
            for (int i = 0; i <= TANH_ENTRIES; i++) begin
                den         = unit + p;
                tanh_lut[i] = (((unit - p) << (SAMPLE_BITS - 1)) + den / 2) / den;
                p           = (p * ratio + (64'd1 << 29)) >> 30;
            end
            errors       = 0;
            results_seen = 0;
            shaped_items = 0;
            restore_defaults();
        endfunction

        function void restore_defaults();
            mode        = 0;
            width_amt   = 0;
            low_mid_amt = 0;
            balance_amt = 0;
            drive_amt   = 0;
            gain        = 8192;
            xover       = 1282;
            side_lp     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [15:0] data);
            case (idx)
                REG_MODE:    mode        = data[2:0];
                REG_WIDTH:   width_amt   = longint'($signed(data));
                REG_LOW_MID: low_mid_amt = longint'($signed(data));
                REG_BALANCE: balance_amt = longint'($signed(data));
                REG_DRIVE:   drive_amt   = longint'($signed(data));
                REG_GAIN:    gain        = longint'(data[14:0]);
                REG_XOVER:   xover       = longint'(data);
                default: ;
            endcase
        endfunction

        static function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        static function sample_t clip24(longint v);
            longint lim;
            lim = longint'(1) <<< (SAMPLE_BITS - 1);
            if (v > lim - 1) v = lim - 1;
            if (v < -lim) v = -lim;
            return sample_t'(v);
        endfunction

        function longint tanh_clip(longint x);
            longint unsigned ax;
            longint unsigned sc;
            longint unsigned idx;
            longint          frac;
            longint          lo;
            longint          hi;
            longint          t;
            ax  = (x < 0) ? longint'(-x) : longint'(x);
            sc  = ax * TANH_ENTRIES;
            idx = sc >> (SAMPLE_BITS + 17);
            if (idx >= TANH_ENTRIES) begin
                t = longint'(tanh_lut[TANH_ENTRIES]);
            end else begin
                frac = longint'((sc >> (SAMPLE_BITS + 1)) & 64'hFFFF);
                lo   = longint'(tanh_lut[idx]);
                hi   = longint'(tanh_lut[idx + 1]);
                t    = lo + (((hi - lo) * frac) >>> 16);
            end
            return (x < 0) ? -t : t;
        endfunction

        // Works out the output pair of one accepted item.
        function void note_input(sample_t a_in, sample_t b_in);
            sample_pair_t pr;
            longint a;
            longint b;
            longint mid;
            longint side;
            longint lp;
            longint amt;
            longint gl;
            longint gr;
            longint v1;
            longint v2;
            a = a_in;
            b = b_in;
            if (!mode[MODE_ENABLE]) begin
                pr.first  = a_in;
                pr.second = b_in;
                expected_pairs.push_back(pr);
                return;
            end
            shaped_items++;
            if (mode[MODE_IN_MS]) begin
                mid  = a;
                side = b;
            end else begin
                mid  = (a + b) >>> 1;
                side = (a - b) >>> 1;
            end
            side = round_shift(side * (32768 + width_amt), 15);
            // Low band rescale, outside the deadband only.
            if (low_mid_amt >= DEADBAND || low_mid_amt <= -DEADBAND) begin
                lp = side_lp + round_shift(xover * (side - side_lp), 16);
                if (lp > 64'sd2147483647) lp = 64'sd2147483647;
                if (lp < -64'sd2147483648) lp = -64'sd2147483648;
                side_lp = lp;
                side    = side - lp + round_shift(lp * (32768 + low_mid_amt), 15);
            end
            // Soft clip blend on mid.
            if (drive_amt >= DEADBAND || drive_amt <= -DEADBAND) begin
                amt = (drive_amt < 0) ? -drive_amt : drive_amt;
                mid = round_shift(mid * (32768 - amt) +
                                  tanh_clip(mid * (32768 + 8 * amt)) * amt, 15);
            end
            gl = 65536 - ((balance_amt > 0) ? balance_amt : 0);
            gr = 65536 - ((balance_amt < 0) ? -balance_amt : 0);
            if (mode[MODE_OUT_MS]) begin
                v1 = mid;
                v2 = side;
            end else begin
                v1 = mid + side;
                v2 = mid - side;
            end
            pr.first  = clip24(round_shift(round_shift(v1 * gl, 16) * gain, 13));
            pr.second = clip24(round_shift(round_shift(v2 * gr, 16) * gain, 13));
            expected_pairs.push_back(pr);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(sample_t f, sample_t s);
            sample_pair_t pr;
            results_seen++;
            if (expected_pairs.size() == 0) begin
                report($sformatf("unexpected result %0d %0d", f, s));
                return;
            end
            pr = expected_pairs.pop_front();
            if (f !== pr.first)
                report($sformatf("result %0d first_out %0d, want %0d",
                                 results_seen, f, pr.first));
            if (s !== pr.second)
                report($sformatf("result %0d second_out %0d, want %0d",
                                 results_seen, s, pr.second));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    sample_t     s_first_sample;
    sample_t     s_second_sample;
    logic        m_valid;
    logic        m_ready;
    sample_t     m_first_out;
    sample_t     m_second_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    imager_scoreboard sb;
    int               tx_idle;
    int               rx_idle;
    bit               hold_rx;
    int               cfg_sets;

    stereo_mid_side_imager_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_sample  (s_first_sample),
        .s_second_sample (s_second_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_out     (m_first_out),
        .m_second_out    (m_second_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous overall limit.
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Monitor of all three handshakes, feeding the scoreboard in one process.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (s_valid && s_ready) sb.note_input(s_first_sample, s_second_sample);
            if (m_valid && m_ready) sb.check_result(m_first_out, m_second_out);
        end
    end

    // Receiver with random stalls, or a long hold-off when asked.
    always @(posedge aclk) begin
        if (hold_rx || !aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Offers one item and waits for it to be taken; valid stays high afterwards.
    task send_item(sample_t a, sample_t b);
        if (tx_idle > 0 && $urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_first_sample  <= a;
        s_second_sample <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task write_reg(cfg_reg_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Lets the block drain completely before registers change.
    task drain();
        s_valid <= 1'b0;
        while (sb.expected_pairs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task apply_cfg(logic [2:0] mode, logic [15:0] w, logic [15:0] l, logic [15:0] bal,
                   logic [15:0] d, logic [14:0] g, logic [15:0] c);
        drain();
        write_reg(REG_MODE, {13'd0, mode});
        write_reg(REG_WIDTH, w);
        write_reg(REG_LOW_MID, l);
        write_reg(REG_BALANCE, bal);
        write_reg(REG_DRIVE, d);
        write_reg(REG_GAIN, {1'b0, g});
        write_reg(REG_XOVER, c);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cfg_sets++;
    endtask

    function automatic logic [15:0] pick_amount();
        logic [15:0] picks[6] = '{16'h8000, 16'h7FFF, 16'd0, 16'd327, 16'd328, 16'hFEB8};
        if ($urandom_range(0, 4) == 0) return picks[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    function automatic sample_t pick_sample();
        sample_t picks[4] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
        case ($urandom_range(0, 9))
            0: return picks[$urandom_range(0, 3)];
            1, 2: return sample_t'($signed(16'($urandom)));
            default: return sample_t'($urandom);
        endcase
    endfunction

    task directed_set(logic [2:0] mode, logic [15:0] w, logic [15:0] l, logic [15:0] bal,
                      logic [15:0] d, logic [14:0] g, logic [15:0] c);
        apply_cfg(mode, w, l, bal, d, g, c);
        send_item(24'h7FFFFF, 24'h7FFFFF);
        send_item(24'h800000, 24'h7FFFFF);
        send_item(24'h7FFFFF, 24'h800000);
        send_item(24'h800000, 24'h800000);
    endtask

    initial begin
        logic [14:0] g;
        sb              = new();
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_first_sample  = '0;
        s_second_sample = '0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        hold_rx         = 1'b0;
        tx_idle         = 14;
        rx_idle         = 82;
        cfg_sets        = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reset defaults (bypass), then extreme settings.
        send_item(24'h7FFFFF, 24'h800000);
        send_item(24'h000000, 24'hFFFFFF);
        directed_set(3'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 15'd32637, 16'hFFFF);
        directed_set(3'd7, 16'h8000, 16'd327, 16'h8000, 16'h8000, 15'd2056, 16'd0);
        directed_set(3'd3, 16'd0, 16'd328, 16'd0, 16'd327, 15'h7FFF, 16'd1282);
        directed_set(3'd5, 16'hFEB8, 16'h7FFF, 16'h4000, 16'hFEB8, 15'd0, 16'd1282);
        directed_set(3'd6, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 16'hFFFF);

        // Random part in segments, each with its own setting, spread over three idling phases.
        for (int seg = 0; seg < 13; seg++) begin
            if (seg == 5) begin
                tx_idle = 82;
                rx_idle = 14;
            end else if (seg == 9) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            g = ($urandom_range(0, 5) == 0) ? 15'($urandom) : 15'($urandom_range(2056, 32637));
            apply_cfg(($urandom_range(0, 5) == 0) ? 3'($urandom) : {2'($urandom), 1'b1},
                      pick_amount(), pick_amount(), pick_amount(), pick_amount(), g,
                      ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
            // Long receiver hold-off while items keep coming, filling the queue.
            if (seg == 10) begin
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 100; n++) send_item(pick_sample(), pick_sample());
        end
        s_valid <= 1'b0;

        while (sb.expected_pairs.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.expected_pairs.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_pairs.size()));
        $display("Run covered %0d results, %0d of them processed, over %0d register settings.",
                 sb.results_seen, sb.shaped_items, cfg_sets);
        $display("Idling phases: slow receiver, slow sender, no idling, plus a long stall.");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
